/* src/mep_pkg.sv */
package mep_pkg;

    // field and datapath widths
    localparam int COORD_BITS   = 10;
    localparam int FRAC_BITS    = 26;
    localparam int COUNT_BITS   = 16;
    localparam int PALETTE_SIZE = 7;
    localparam int PAL_BITS     = 3;
    localparam int WORD_BITS    = 32;
    localparam int PROD_BITS    = 2 * WORD_BITS;
    localparam int SCREEN_BITS  = COORD_BITS + 1;
    localparam int INDEX_BITS   = 3;

    // escape bound: 4.0 in the squared (Q12.52) scale
    localparam logic [PROD_BITS-1:0] ESCAPE_BOUND = PROD_BITS'(4) << (2 * FRAC_BITS);

    // register reset values
    localparam logic signed [WORD_BITS-1:0] RESET_REAL_START = -32'sd154350387;
    localparam logic signed [WORD_BITS-1:0] RESET_IMAG_START = -32'sd80530637;
    localparam logic signed [WORD_BITS-1:0] RESET_REAL_STEP  = 32'sd671089;
    localparam logic signed [WORD_BITS-1:0] RESET_IMAG_STEP  = 32'sd671089;
    localparam logic [COUNT_BITS-1:0]       RESET_LIMIT      = COUNT_BITS'(32);

    // register indexes of the configuration port
    typedef enum logic [INDEX_BITS-1:0] {
        REG_REAL_START = 3'd0,
        REG_IMAG_START = 3'd1,
        REG_REAL_STEP  = 3'd2,
        REG_IMAG_STEP  = 3'd3,
        REG_ITER_LIMIT = 3'd4,
        REG_OFFSET_X   = 3'd5,
        REG_OFFSET_Y   = 3'd6
    } reg_index_t;

    // view and screen settings
    typedef struct packed {
        logic signed [WORD_BITS-1:0] real_start;
        logic signed [WORD_BITS-1:0] imag_start;
        logic signed [WORD_BITS-1:0] real_step;
        logic signed [WORD_BITS-1:0] imag_step;
        logic [COUNT_BITS-1:0]       iteration_limit;
        logic [COORD_BITS-1:0]       offset_x;
        logic [COORD_BITS-1:0]       offset_y;
    } cfg_t;

    // one finished pixel
    typedef struct packed {
        logic [SCREEN_BITS-1:0] screen_x;
        logic [SCREEN_BITS-1:0] screen_y;
        logic                   in_set;
        logic [COUNT_BITS-1:0]  escape_count;
        logic [PAL_BITS-1:0]    palette_index;
        logic                   invert_out;
    } result_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_CR,
        ST_MUL_CI,
        ST_LOAD_CI,
        ST_SQ_R,
        ST_SQ_I,
        ST_CHECK,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    // clamp a wide signed value to the 32-bit signed range
    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [PROD_BITS-1:0] v
    );
        logic signed [PROD_BITS-1:0] hi;
        logic signed [PROD_BITS-1:0] lo;
        logic signed [WORD_BITS-1:0] r;
        hi = PROD_BITS'({1'b0, {(WORD_BITS-1){1'b1}}});
        lo = -hi - PROD_BITS'(1);
        if (v > hi)
            r = {1'b0, {(WORD_BITS-1){1'b1}}};
        else if (v < lo)
            r = {1'b1, {(WORD_BITS-1){1'b0}}};
        else
            r = v[WORD_BITS-1:0];
        return r;
    endfunction

endpackage

/* src/mep_cfg.sv */
module mep_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mep_pkg::INDEX_BITS-1:0]        cfg_index,
    input  logic [mep_pkg::WORD_BITS-1:0]         cfg_data,
    output mep_pkg::cfg_t                         cfg
);
    import mep_pkg::*;

    cfg_t cfg_reg;

    // register file, unused indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.real_start      <= RESET_REAL_START;
            cfg_reg.imag_start      <= RESET_IMAG_START;
            cfg_reg.real_step       <= RESET_REAL_STEP;
            cfg_reg.imag_step       <= RESET_IMAG_STEP;
            cfg_reg.iteration_limit <= RESET_LIMIT;
            cfg_reg.offset_x        <= '0;
            cfg_reg.offset_y        <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REAL_START: cfg_reg.real_start      <= cfg_data;
                REG_IMAG_START: cfg_reg.imag_start      <= cfg_data;
                REG_REAL_STEP:  cfg_reg.real_step       <= cfg_data;
                REG_IMAG_STEP:  cfg_reg.imag_step       <= cfg_data;
                REG_ITER_LIMIT: cfg_reg.iteration_limit <= cfg_data[COUNT_BITS-1:0];
                REG_OFFSET_X:   cfg_reg.offset_x        <= cfg_data[COORD_BITS-1:0];
                REG_OFFSET_Y:   cfg_reg.offset_y        <= cfg_data[COORD_BITS-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/mep_mul.sv */
module mep_mul (
    input  logic                                  clk,
    input  logic signed [mep_pkg::WORD_BITS-1:0]  a,
    input  logic signed [mep_pkg::WORD_BITS-1:0]  b,
    output logic signed [mep_pkg::PROD_BITS-1:0]  p
);
    import mep_pkg::*;

    logic signed [PROD_BITS-1:0] p_reg;

    // shared 32x32 signed multiplier with registered product
    always_ff @(posedge clk)
    begin
        p_reg <= PROD_BITS'(a) * PROD_BITS'(b);
    end

    assign p = p_reg;

endmodule

/* src/mep_core.sv */
module mep_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mep_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mep_pkg::COORD_BITS-1:0]    pixel_col,
    input  logic [mep_pkg::COORD_BITS-1:0]    pixel_row,
    input  logic                              invert_in,
    input  logic                              slot_free,
    output logic                              res_load,
    output mep_pkg::result_t                  res
);
    import mep_pkg::*;

    state_t state_reg, state_next;

    logic                         first_reg, first_next;
    logic                         inside_reg, inside_next;
    logic [COUNT_BITS-1:0]        count_reg, count_next;
    logic [PAL_BITS-1:0]          pal_reg, pal_next;

    logic [COORD_BITS-1:0]        col_reg, col_next;
    logic [COORD_BITS-1:0]        row_reg, row_next;
    logic                         inv_reg, inv_next;
    logic signed [WORD_BITS-1:0]  cr_reg, cr_next;
    logic signed [WORD_BITS-1:0]  ci_reg, ci_next;
    logic signed [WORD_BITS-1:0]  zr_reg, zr_next;
    logic signed [WORD_BITS-1:0]  zi_reg, zi_next;
    logic signed [PROD_BITS-1:0]  rr_reg, rr_next;
    logic signed [PROD_BITS-1:0]  diff_reg, diff_next;

    logic signed [WORD_BITS-1:0]  mul_a;
    logic signed [WORD_BITS-1:0]  mul_b;
    logic signed [PROD_BITS-1:0]  prod;

    logic [PROD_BITS-1:0]         mag;
    logic [COUNT_BITS:0]          count_inc;
    logic signed [PROD_BITS-1:0]  re_sum;
    logic signed [PROD_BITS-1:0]  im_sum;

    mep_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // squared magnitude of the current z and the next iteration count
    assign mag       = rr_reg + prod;
    assign count_inc = {1'b0, count_reg} + (COUNT_BITS+1)'(1);

    // new z before clamping: floor-shifted products plus c
    assign re_sum = (diff_reg >>> FRAC_BITS) + PROD_BITS'(cr_reg);
    assign im_sum = (prod >>> (FRAC_BITS - 1)) + PROD_BITS'(ci_reg);

    // multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_MUL_CR:
            begin
                mul_a = WORD_BITS'(col_reg);
                mul_b = cfg.real_step;
            end
            ST_MUL_CI:
            begin
                mul_a = WORD_BITS'(row_reg);
                mul_b = cfg.imag_step;
            end
            ST_SQ_I:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = (state_reg == ST_CHECK) ? zi_reg : zr_reg;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        first_next  = first_reg;
        inside_next = inside_reg;
        count_next  = count_reg;
        pal_next    = pal_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        inv_next    = inv_reg;
        cr_next     = cr_reg;
        ci_next     = ci_reg;
        zr_next     = zr_reg;
        zi_next     = zi_reg;
        rr_next     = rr_reg;
        diff_next   = diff_reg;
        in_ready    = 1'b0;
        res_load    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    col_next    = pixel_col;
                    row_next    = pixel_row;
                    inv_next    = invert_in;
                    zr_next     = '0;
                    zi_next     = '0;
                    count_next  = '0;
                    pal_next    = '0;
                    first_next  = 1'b1;
                    inside_next = 1'b1;
                    state_next  = ST_MUL_CR;
                end
            end
            ST_MUL_CR:
                state_next = ST_MUL_CI;
            ST_MUL_CI:
            begin
                cr_next    = sat_word(PROD_BITS'(cfg.real_start) + prod);
                state_next = ST_LOAD_CI;
            end
            ST_LOAD_CI:
            begin
                ci_next = sat_word(PROD_BITS'(cfg.imag_start) + prod);
                // a zero limit runs no iteration
                if (cfg.iteration_limit == '0)
                    state_next = ST_FINISH;
                else
                    state_next = ST_UPDATE;
            end
            ST_SQ_R:
                state_next = ST_SQ_I;
            ST_SQ_I:
            begin
                rr_next    = prod;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                diff_next = rr_reg - prod;
                if (mag > ESCAPE_BOUND)
                begin
                    inside_next = 1'b0;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    count_next = count_inc[COUNT_BITS-1:0];
                    pal_next   = (pal_reg == PAL_BITS'(PALETTE_SIZE - 1))
                                 ? '0 : pal_reg + PAL_BITS'(1);
                    if (count_inc[COUNT_BITS-1:0] == cfg.iteration_limit)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // first pass starts from z = 0, so the new z is c itself
                if (first_reg)
                begin
                    zr_next = cr_reg;
                    zi_next = ci_reg;
                end
                else
                begin
                    zr_next = sat_word(re_sum);
                    zi_next = sat_word(im_sum);
                end
                first_next = 1'b0;
                state_next = ST_SQ_R;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            first_reg  <= 1'b1;
            inside_reg <= 1'b1;
            count_reg  <= '0;
            pal_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            first_reg  <= first_next;
            inside_reg <= inside_next;
            count_reg  <= count_next;
            pal_reg    <= pal_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        col_reg  <= col_next;
        row_reg  <= row_next;
        inv_reg  <= inv_next;
        cr_reg   <= cr_next;
        ci_reg   <= ci_next;
        zr_reg   <= zr_next;
        zi_reg   <= zi_next;
        rr_reg   <= rr_next;
        diff_reg <= diff_next;
    end

    // result fields
    always_comb
    begin
        res.screen_x      = SCREEN_BITS'(col_reg) + SCREEN_BITS'(cfg.offset_x);
        res.screen_y      = SCREEN_BITS'(row_reg) + SCREEN_BITS'(cfg.offset_y);
        res.in_set        = inside_reg;
        res.escape_count  = count_reg;
        res.palette_index = inside_reg ? '0 : pal_reg;
        res.invert_out    = inv_reg;
    end

endmodule

/* src/mandelbrot_escape_time_pixel.sv */
// Escape-time Mandelbrot pixel unit.
// Input channel (in_valid/in_ready) carries one pixel: pixel_col, pixel_row
// and invert_in. The pixel maps to c = start + pixel * step in signed Q6.26,
// then z = z^2 + c runs from zero until |z|^2 > 4 or the iteration limit.
// Output channel (out_valid/out_ready) carries screen_x, screen_y, in_set,
// escape_count, palette_index (count mod 7, zero when in the set) and
// invert_out. The configuration port (cfg_we, cfg_index, cfg_data) writes
// one register per cycle; the user must write it only while the unit is
// idle, which the block itself does not enforce. One pixel at a time: a
// single 32x32 multiplier is shared by every product, so an iteration runs
// as two squares, cross product and update. A new pixel is taken only once
// the previous result has been loaded into the output register.
// A held result sits in the output register while the next pixel is taken
// and computed; the unit stalls in its last step only when that register is
// still full. Reset restores the default view (real_start, imag_start,
// steps, limit 32, zero offsets) and empties the output register.
module mandelbrot_escape_time_pixel (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [mep_pkg::INDEX_BITS-1:0]         cfg_index,
    input  logic [mep_pkg::WORD_BITS-1:0]          cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [mep_pkg::COORD_BITS-1:0]         pixel_col,
    input  logic [mep_pkg::COORD_BITS-1:0]         pixel_row,
    input  logic                                   invert_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [mep_pkg::SCREEN_BITS-1:0]        screen_x,
    output logic [mep_pkg::SCREEN_BITS-1:0]        screen_y,
    output logic                                   in_set,
    output logic [mep_pkg::COUNT_BITS-1:0]         escape_count,
    output logic [mep_pkg::PAL_BITS-1:0]           palette_index,
    output logic                                   invert_out
);
    import mep_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t res_reg;
    logic    res_load;
    logic    slot_free;
    logic    out_valid_reg;

    mep_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mep_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_col (pixel_col),
        .pixel_row (pixel_row),
        .invert_in (invert_in),
        .slot_free (slot_free),
        .res_load  (res_load),
        .res       (res)
    );

    // output register is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || out_ready;

    // output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (res_load)
            res_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign screen_x      = res_reg.screen_x;
    assign screen_y      = res_reg.screen_y;
    assign in_set        = res_reg.in_set;
    assign escape_count  = res_reg.escape_count;
    assign palette_index = res_reg.palette_index;
    assign invert_out    = res_reg.invert_out;

endmodule
